// ===== hdl/plop_pkg.sv =====
// Package for the preorder-to-level-order placer: field widths,
// configuration register indexes and the component limit.
// No dependencies.
package plop_pkg;

  localparam int COUNT_W    = 16;  // level counts, node numbers, slots
  localparam int COMP_W     = 3;   // component number within a node
  localparam int COMPS_W    = 4;   // components_per_node register
  localparam int DEST_W     = 19;  // level-order word index
  localparam int PROD_W     = 20;  // slot times components, before masking
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [COMPS_W-1:0] COMPS_MAX = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_TREE_NODES = 4'd0;
  localparam cfg_index_t CFG_COMPONENTS = 4'd1;

endpackage

// ===== hdl/preorder_to_level_order_placer_unit.sv =====
// Top level of the preorder-to-level-order placer.
// Depends on plop_pkg for widths and configuration register indexes.
//
// The block takes the component words of binary tree nodes in depth-first
// preorder and gives each word its word index in breadth-first layout
// (slot * components_per_node + component), with the word passed through and
// tree_done set on the last word of each subtree. Level L starts at slot
// 2^L - 1; a per-level count of placed nodes lives in a small synchronous
// memory with a registered read. The first word of every node except the
// first node of a subtree takes a read-modify-write of its level count:
// read the level count, then increment, write back and place the word, with
// the input stalled meanwhile. Every other word is placed as it is accepted.
// Level climbing after a node runs as one combinational priority search over
// a parity bit per level. Valid bits per level make an unwritten count read
// as its reset value (one for level zero, zero elsewhere), and the end of a
// subtree clears them at once: no clearing pass is needed. Configuration is
// accepted every cycle and must be written only while the block is idle.
module preorder_to_level_order_placer_unit
  import plop_pkg::*;
#(
  parameter int MAX_LEVELS = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WORD_WIDTH-1:0]  in_word_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DEST_W-1:0]      out_dest_index,
  output logic [WORD_WIDTH-1:0]  out_out_value,
  output logic                   out_tree_done,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PASS_W = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

  // Level zero starts out with a count of one, all others at zero.
  localparam logic [MAX_LEVELS-1:0] ODD_RESET = MAX_LEVELS'(1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_RMW
  } state_t;

  state_t                  state_r, state_nxt;

  logic [COUNT_W-1:0]      tree_nodes_r;
  logic [COMPS_W-1:0]      comps_cfg_r;

  logic [LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [COUNT_W-1:0]      node_r, node_nxt;
  logic [COMP_W-1:0]       comp_r, comp_nxt;
  logic [COUNT_W-1:0]      slot_r;
  logic [MAX_LEVELS-1:0]   cnt_valid_r;
  logic [MAX_LEVELS-1:0]   odd_r, odd_nxt;
  logic [WORD_WIDTH-1:0]   word_r;

  logic                    out_valid_r;
  logic [DEST_W-1:0]       out_dest_r;
  logic [WORD_WIDTH-1:0]   out_value_r;
  logic                    out_done_r;

  // Level count memory
  logic [COUNT_W-1:0]      count_mem [MAX_LEVELS];
  logic [COUNT_W-1:0]      rd_data_r;

  logic [COUNT_W-1:0]      size;
  logic [COMPS_W-1:0]      comps;
  logic                    out_free;
  logic                    in_xfer;
  logic                    need_rmw;
  logic                    fire;
  logic                    in_rmw;
  logic [COUNT_W-1:0]      cnt_cur;
  logic [COUNT_W-1:0]      cnt_inc;
  logic [COUNT_W:0]        start_ext;
  logic [COUNT_W-1:0]      rmw_slot;
  logic [COUNT_W-1:0]      slot_use;
  logic [WORD_WIDTH-1:0]   word_use;
  logic [PROD_W-1:0]       dest_full;
  logic                    last_word;
  logic                    last_node;
  logic [COUNT_W+1:0]      deeper_start;
  logic                    descend;
  logic [LVL_W-1:0]        climb_lvl;
  logic [LVL_W-1:0]        adv_lvl;

  // Configuration: always ready, takes effect at once.
  assign cfg_ready = 1'b1;

  // Register values as the stepping logic sees them.
  assign size  = (tree_nodes_r == '0) ? COUNT_W'(1) : tree_nodes_r;
  assign comps = (comps_cfg_r == '0)      ? COMPS_W'(1) :
                 (comps_cfg_r > COMPS_MAX) ? COMPS_MAX : comps_cfg_r;

  // Accept a word only in IDLE and only when the output register empties.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign in_rmw   = (state_r == S_RMW);

  // The first word of a non-first node must fetch its level count.
  assign need_rmw = (comp_r == '0) && (node_r != '0);
  assign fire     = in_rmw || (in_xfer && !need_rmw);

  // Count as read, with unwritten levels giving their reset value.
  assign cnt_cur = cnt_valid_r[lvl_r] ? rd_data_r :
                   ((lvl_r == '0) ? COUNT_W'(1) : COUNT_W'(0));
  assign cnt_inc = (cnt_cur == COUNT_SAT) ? cnt_cur : cnt_cur + COUNT_W'(1);

  // Level start 2^L - 1; levels at or beyond 16 wrap to all ones.
  assign start_ext = ((COUNT_W+1)'(1) << lvl_r) - (COUNT_W+1)'(1);
  assign rmw_slot  = start_ext[COUNT_W-1:0] + cnt_cur;

  // Within a node keep the slot; the first node always sits in slot zero.
  assign slot_use = in_rmw ? rmw_slot : ((comp_r == '0) ? '0 : slot_r);
  assign word_use = in_rmw ? word_r : in_word_value;

  assign dest_full = PROD_W'(slot_use) * PROD_W'(comps) + PROD_W'(comp_r);

  assign last_word = ({1'b0, comp_r} + COMPS_W'(1)) >= comps;
  assign last_node = ({1'b0, node_r} + (COUNT_W+1)'(1)) >= {1'b0, size};

  // Parity per level after this node's count update.
  always_comb begin
    odd_nxt = odd_r;
    if (in_rmw) begin
      odd_nxt[lvl_r] = cnt_inc[0];
    end
  end

  // Descend if the next level starts inside the subtree.
  assign deeper_start = ((COUNT_W+2)'(1) << ((COUNT_W+2)'(lvl_r) + (COUNT_W+2)'(1)))
                        - (COUNT_W+2)'(1);
  assign descend = (deeper_start < {2'b00, size}) &&
                   ((32'(lvl_r) + 32'd1) < 32'(MAX_LEVELS));

  // Climb to the deepest level at or above the current one with an odd
  // count, stopping at the root.
  always_comb begin
    climb_lvl = '0;
    for (int j = 1; j < MAX_LEVELS; j++) begin
      if ((LVL_W'(j) <= lvl_r) && odd_nxt[j]) begin
        climb_lvl = LVL_W'(j);
      end
    end
  end

  assign adv_lvl = descend ? lvl_r + LVL_W'(1) : climb_lvl;

  // Next tree position after the word that fires.
  always_comb begin
    lvl_nxt   = lvl_r;
    node_nxt  = node_r;
    comp_nxt  = comp_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && need_rmw) begin
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fire) begin
      if (last_word) begin
        if (last_node) begin
          lvl_nxt  = '0;
          node_nxt = '0;
          comp_nxt = '0;
        end else begin
          lvl_nxt  = adv_lvl;
          node_nxt = node_r + COUNT_W'(1);
          comp_nxt = '0;
        end
      end else begin
        comp_nxt = comp_r + COMP_W'(1);
      end
    end
  end

  // Count memory: registered read at the current level, write back in RMW.
  always_ff @(posedge clk) begin
    rd_data_r <= count_mem[lvl_r];
    if (in_rmw) begin
      count_mem[lvl_r] <= cnt_inc;
    end
  end

  // State, tree position, level flags and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tree_nodes_r <= COUNT_W'(1);
      comps_cfg_r  <= COMPS_W'(1);
      lvl_r        <= '0;
      node_r       <= '0;
      comp_r       <= '0;
      cnt_valid_r  <= '0;
      odd_r        <= ODD_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      node_r  <= node_nxt;
      comp_r  <= comp_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TREE_NODES: tree_nodes_r <= cfg_data;
          CFG_COMPONENTS: comps_cfg_r  <= cfg_data[COMPS_W-1:0];
          default: ;
        endcase
      end

      // End of subtree: drop every count back to its reset value.
      if (fire && last_word && last_node) begin
        cnt_valid_r <= '0;
        odd_r       <= ODD_RESET;
      end else if (in_rmw) begin
        cnt_valid_r[lvl_r] <= 1'b1;
        odd_r              <= odd_nxt;
      end

      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // Payload registers, not reset.
      if (in_xfer) begin
        word_r <= in_word_value;
      end
      if (fire) begin
        slot_r      <= slot_use;
        out_dest_r  <= dest_full[DEST_W-1:0];
        out_value_r <= WORD_WIDTH'(word_use[PASS_W-1:0]);
        out_done_r  <= last_word && last_node;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_index = out_dest_r;
  assign out_out_value  = out_value_r;
  assign out_tree_done  = out_done_r;

  // No word is taken while a count read-modify-write is in flight.
  a_no_accept_in_rmw : assert property (@(posedge clk) disable iff (!rst_n)
    in_rmw |-> in_stall)
    else $error("input transfer during count update");

  // A count fetch only happens for the first word of a non-first node.
  a_rmw_first_word : assert property (@(posedge clk) disable iff (!rst_n)
    in_rmw |-> (comp_r == '0) && (node_r != '0))
    else $error("count update outside a node's first word");

  // After the last word of a subtree the position starts over.
  a_restart_after_done : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_word && last_node) |=>
      (node_r == '0) && (comp_r == '0) && (lvl_r == '0) && (cnt_valid_r == '0))
    else $error("state not cleared after subtree");

  // The level never runs past the deepest one.
  a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
    32'(lvl_r) < 32'(MAX_LEVELS))
    else $error("level out of range");

endmodule

// ===== tb/plop_board_pkg.sv =====
// Scoreboard for the preorder-to-level-order placer testbench: a slot predictor
// with its own copy of the level counts and registers, and a queue of expected
// placements. Depends on plop_pkg.
package plop_board_pkg;
  import plop_pkg::*;

  localparam int LEVELS = 16;
  localparam int WORD_W = 32;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [WORD_W-1:0] value;
    logic              done;
  } placement_t;

  class placement_board;
    logic [COUNT_W-1:0] tree_nodes;
    logic [COMPS_W-1:0] comps_reg;
    logic [COUNT_W-1:0] level_count [LEVELS];
    int unsigned        level;
    logic [COUNT_W-1:0] node_num;
    logic [COMP_W-1:0]  comp_num;
    logic [COUNT_W-1:0] slot;
    placement_t         pending_placements [$];
    int                 failures;

    function new();
      tree_nodes = 1;
      comps_reg  = 1;
      failures   = 0;
      clear_tree();
    endfunction

    function void clear_tree();
      foreach (level_count[i]) level_count[i] = '0;
      level_count[0] = 1;
      level    = 0;
      node_num = '0;
      comp_num = '0;
      slot     = '0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TREE_NODES) begin
        tree_nodes = data[COUNT_W-1:0];
      end else if (idx == CFG_COMPONENTS) begin
        comps_reg = data[COMPS_W-1:0];
      end
    endfunction

    // Descend one level if the next level still lies inside the tree, else climb
    // past every level whose count is even.
    function void descend_or_climb(int size);
      if ((2 << level) - 1 < size && level + 1 < LEVELS) begin
        level++;
      end else begin
        while (level > 0 && !level_count[level][0]) level--;
      end
    endfunction

    function void note_word(logic [WORD_W-1:0] w);
      int         size;
      int         comps;
      logic       last_word;
      logic       last_node;
      placement_t p;
      size  = (tree_nodes == 0) ? 1 : int'(tree_nodes);
      comps = (comps_reg == 0) ? 1 :
              ((comps_reg > COMPS_MAX) ? int'(COMPS_MAX) : int'(comps_reg));
      if (comp_num == 0) begin
        if (node_num == 0) begin
          slot = '0;
        end else begin
          slot = COUNT_W'((1 << level) - 1 + int'(level_count[level]));
          if (level_count[level] != COUNT_SAT) level_count[level]++;
        end
      end
      p.dest    = DEST_W'(int'(slot) * comps + int'(comp_num));
      p.value   = w;
      last_word = int'(comp_num) + 1 >= comps;
      last_node = int'(node_num) + 1 >= size;
      p.done    = last_word && last_node;
      pending_placements = {pending_placements, p};
      if (!last_word) begin
        comp_num++;
      end else if (last_node) begin
        clear_tree();
      end else begin
        descend_or_climb(size);
        node_num++;
        comp_num = '0;
      end
    endfunction

    function void check_placement(logic [DEST_W-1:0] dest, logic [WORD_W-1:0] value,
                                  logic done);
      placement_t e;
      if (pending_placements.size() == 0) begin
        $error("unexpected placement: dest_index %0d out_value %h tree_done %b",
               dest, value, done);
        failures++;
        return;
      end
      e = pending_placements.pop_front();
      if (dest !== e.dest) begin
        $error("dest_index: expected %0d, got %0d", e.dest, dest);
        failures++;
      end
      if (value !== e.value) begin
        $error("out_value: expected %h, got %h", e.value, value);
        failures++;
      end
      if (done !== e.done) begin
        $error("tree_done: expected %b, got %b", e.done, done);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Testbench top for preorder_to_level_order_placer_unit: directed corner words,
// then random phases over many register settings and idling patterns.
// Depends on plop_pkg and plop_board_pkg.
module tb;
  import plop_pkg::*;
  import plop_board_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [WORD_W-1:0]     in_word_value = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [DEST_W-1:0]     out_dest_index;
  logic [WORD_W-1:0]     out_out_value;
  logic                  out_tree_done;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index     = CFG_TREE_NODES;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  idle_mode_t     idle_mode = IDLE_NONE;
  placement_board board;

  preorder_to_level_order_placer_unit #(
    .MAX_LEVELS(LEVELS),
    .WORD_WIDTH(WORD_W)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word_value (in_word_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dest_index(out_dest_index),
    .out_out_value (out_out_value),
    .out_tree_done (out_tree_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Hard stop well beyond the slowest legal run, a few thousand words with
  // heavy idling on both sides.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:   return $urandom_range(0, 99) < 12;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:     return $urandom_range(0, 99) < 12;
      default:       return 1'b0;
    endcase
  endfunction

  // Receiver side: decide the stall for the next edge at every falling edge.
  always @(negedge clk) begin
    out_stall <= receiver_stalls();
  end

  // One monitor for all three channels, so that an input, a register write
  // and a result landing on the same edge are handled in a fixed order:
  // register first, then the input word, then the result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_word(in_word_value);
      if (out_valid && !out_stall) begin
        board.check_placement(out_dest_index, out_out_value, out_tree_done);
      end
    end
  end

  // Offer one word, holding it until the transfer; valid stays high on
  // return so back-to-back words need no second assignment in one step.
  task automatic send_word(input logic [WORD_W-1:0] w);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_word_value <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected placement has come back, then
  // give the count memory time to finish its write-back.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending_placements.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] nodes,
                              input logic [CFG_DATA_W-1:0] comps);
    write_reg(CFG_TREE_NODES, nodes);
    write_reg(CFG_COMPONENTS, comps);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                    n_words;
    int                    eff_nodes;
    int                    eff_comps;
    int                    tree_words;
    int                    pause_at;
    int                    pick;
    logic [CFG_DATA_W-1:0] nodes;
    logic [CFG_DATA_W-1:0] comps;
    board = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: every word is a whole one-node tree.
    send_word('0);
    send_word('1);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    settle();

    // Zero tree size and zero components both act as one.
    program_regs('0, '0);
    send_word(32'h8000_0000);
    send_word(32'h0000_0001);
    settle();

    // Component count above the limit saturates; also hit an index that
    // names no register, which must change nothing.
    write_reg(cfg_index_t'($urandom_range(int'(CFG_COMPONENTS) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom()));
    program_regs(16'd2, 16'd15);
    repeat (16) send_word($urandom());
    settle();

    for (int p = 0; p < 20; p++) begin
      case (p)
        0: begin nodes = 16'hFFFF; comps = 16'd1; end  // walk down to the last level
        1: begin nodes = 16'd7;    comps = 16'd8; end  // full three-level trees
        2: begin nodes = 16'hFFFF; comps = 16'd8; end
        3: begin nodes = 16'd1;    comps = 16'd15; end
        default: begin
          pick  = $urandom_range(0, 9);
          nodes = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 :
                  CFG_DATA_W'($urandom_range(1, 64));
          comps = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 15)) :
                  CFG_DATA_W'($urandom_range(1, 8));
        end
      endcase
      program_regs(nodes, comps);

      eff_nodes  = (nodes == 0) ? 1 : int'(nodes);
      eff_comps  = (comps[COMPS_W-1:0] == 0) ? 1 :
                   ((comps[COMPS_W-1:0] > COMPS_MAX) ? int'(COMPS_MAX) :
                    int'(comps[COMPS_W-1:0]));
      tree_words = eff_nodes * eff_comps;
      if (p == 0) begin
        n_words = 300;
      end else if (tree_words <= 200) begin
        // Mostly whole trees; sometimes stop mid-tree so the next settings
        // land on a partly placed subtree.
        n_words = tree_words * ((100 / tree_words > 1) ? 100 / tree_words : 1);
        if (tree_words > 1 && $urandom_range(0, 3) == 0) begin
          n_words += $urandom_range(1, tree_words - 1);
        end
      end else begin
        n_words = $urandom_range(60, 160);
      end

      idle_mode = idle_mode_t'(p % 4);
      pause_at  = (p % 3 == 1) ? n_words / 2 : -1;
      for (int i = 0; i < n_words; i++) begin
        if (i == pause_at) settle();  // hold off until the pipe is empty
        send_word($urandom());
      end
      settle();
    end

    idle_mode = IDLE_NONE;
    repeat (20) @(negedge clk);
    if (board.failures == 0 && board.pending_placements.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
